/* sv/fflbm_pkg.sv */
// Package for the free-list buffer manager: sizes, command and status codes,
// controller state and the command struct between controller and datapath.
// No dependencies; every other file of the block but fflbm_ram imports it.
`default_nettype none

package fflbm_pkg;

	localparam int MAX_BUFFERS = 64;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = IDX_W + 1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_NOT_IN_USE = 2'd2
	} status_e;

	typedef enum logic {
		S_IDLE,
		S_FETCH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // latch the item and read the list head
		logic exec;    // apply the item and load the result register
		logic cfg_wr;  // write pool_count and re-initialise the pool
	} ctl_cmd_t;

endpackage

`default_nettype wire

/* sv/fflbm_cmd_if.sv */
// Item channel into the buffer manager: command and buffer index.
// Depends on fflbm_pkg.
`default_nettype none

interface fflbm_cmd_if;
	import fflbm_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] command;
	idx_t       buffer_index;

	modport source (output valid, command, buffer_index, input ready);
	modport sink   (input valid, command, buffer_index, output ready);
endinterface

`default_nettype wire

/* sv/fflbm_rsp_if.sv */
// Result channel out of the buffer manager: status, grant and counts.
// Depends on fflbm_pkg.
`default_nettype none

interface fflbm_rsp_if;
	import fflbm_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] status;
	idx_t       granted_index;
	cnt_t       available_count;
	cnt_t       used_count;

	modport source (output valid, status, granted_index, available_count, used_count,
		input ready);
	modport sink   (input valid, status, granted_index, available_count, used_count,
		output ready);
endinterface

`default_nettype wire

/* sv/fflbm_cfg_if.sv */
// Configuration write channel: carries the pool_count write data.
// Depends on fflbm_pkg.
`default_nettype none

interface fflbm_cfg_if;
	import fflbm_pkg::*;

	logic valid;
	logic ready;
	cnt_t data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* sv/fflbm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fflbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

`default_nettype wire

/* sv/fflbm_ctrl.sv */
// Controller of the buffer manager: two-state sequencer and result valid flag.
// Depends on fflbm_pkg.
`default_nettype none

module fflbm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	output      logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	output      fflbm_pkg::ctl_cmd_t cmd
);
	import fflbm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cfg_ready  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				cfg_ready  = 1'b1;
				// configuration writes take precedence over items
				in_ready   = !cfg_valid;
				cmd.cfg_wr = cfg_valid;
				cmd.load   = in_valid && in_ready;
				if (cmd.load) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				// hold the fetched item until the result register is free
				if (slot_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// the result slot must be free whenever an item is applied
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !out_valid_q || out_ready)
		else $error("result register busy at execute");

	a_fetch_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |-> $past(cmd.load) || $past(state_q == S_FETCH))
		else $error("execute without an accepted item");

	a_no_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cfg_wr |-> !cmd.load && state_q == S_IDLE)
		else $error("config write overlaps item");
endmodule

`default_nettype wire

/* sv/fflbm_dp.sv */
// Datapath of the buffer manager: free-list RAM, head/tail/count registers,
// in-use marks and the result register. Depends on fflbm_pkg and fflbm_ram.
`default_nettype none

module fflbm_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fflbm_pkg::ctl_cmd_t cmd,
	input  wire logic [1:0]          in_command,
	input  wire fflbm_pkg::idx_t     in_buffer_index,
	input  wire fflbm_pkg::cnt_t     cfg_data,
	output      logic [1:0]          out_status,
	output      fflbm_pkg::idx_t     out_granted_index,
	output      fflbm_pkg::cnt_t     out_available_count,
	output      fflbm_pkg::cnt_t     out_used_count
);
	import fflbm_pkg::*;

	localparam cnt_t MAX_CNT = CNT_W'(MAX_BUFFERS);
	localparam idx_t LAST_IDX = IDX_W'(MAX_BUFFERS - 1);

	cnt_t pool_count_q;
	idx_t head_q, tail_q;
	cnt_t free_count_q, used_q;
	logic [MAX_BUFFERS-1:0] in_use_q;
	logic [MAX_BUFFERS-1:0] valid_q;
	logic [1:0] command_q;
	idx_t idx_q;

	idx_t ram_rdata;
	idx_t head_entry;

	status_e st_d;
	idx_t    granted_d;
	idx_t    head_d, tail_d;
	cnt_t    free_d, used_d;
	logic    mark_set, mark_clr, ram_we, do_init;
	cnt_t    init_count;
	cnt_t    cfg_sat;

	fflbm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BUFFERS)) u_list (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (idx_q),
		.re    (cmd.load),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// an entry not written since the last refill holds its own index
	assign head_entry = valid_q[head_q] ? ram_rdata : head_q;
	assign cfg_sat    = (cfg_data > MAX_CNT) ? MAX_CNT : cfg_data;

	always_comb begin
		st_d      = ST_OK;
		granted_d = '0;
		head_d    = head_q;
		tail_d    = tail_q;
		free_d    = free_count_q;
		used_d    = used_q;
		mark_set  = 1'b0;
		mark_clr  = 1'b0;
		ram_we    = 1'b0;
		do_init   = 1'b0;
		if (cmd.exec) begin
			priority if (command_q == CMD_ACQUIRE) begin
				if (free_count_q == '0) begin
					st_d = ST_EMPTY;
				end else begin
					granted_d = head_entry;
					head_d    = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
					free_d    = free_count_q - CNT_W'(1);
					if (!in_use_q[head_entry]) begin
						mark_set = 1'b1;
						used_d   = used_q + CNT_W'(1);
					end
				end
			end else if (command_q == CMD_RELEASE) begin
				if ({1'b0, idx_q} >= pool_count_q || !in_use_q[idx_q]) begin
					st_d = ST_NOT_IN_USE;
				end else begin
					mark_clr = 1'b1;
					ram_we   = 1'b1;
					used_d   = used_q - CNT_W'(1);
					tail_d   = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
					free_d   = free_count_q + CNT_W'(1);
				end
			end else if (command_q == CMD_CLEAR) begin
				do_init = 1'b1;
			end else begin
				st_d = ST_OK;
			end
		end
		init_count = cmd.cfg_wr ? cfg_sat : pool_count_q;
		if (cmd.cfg_wr || do_init) begin
			head_d = '0;
			tail_d = (init_count == MAX_CNT) ? '0 : init_count[IDX_W-1:0];
			free_d = init_count;
			used_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_count_q <= MAX_CNT;
			head_q       <= '0;
			tail_q       <= '0;
			free_count_q <= MAX_CNT;
			used_q       <= '0;
			in_use_q     <= '0;
			valid_q      <= '0;
		end else begin
			head_q       <= head_d;
			tail_q       <= tail_d;
			free_count_q <= free_d;
			used_q       <= used_d;
			if (cmd.cfg_wr) begin
				pool_count_q <= cfg_sat;
			end
			if (cmd.cfg_wr || do_init) begin
				in_use_q <= '0;
				valid_q  <= '0;
			end else begin
				if (mark_set) begin
					in_use_q[head_entry] <= 1'b1;
				end
				if (mark_clr) begin
					in_use_q[idx_q] <= 1'b0;
				end
				if (ram_we) begin
					valid_q[tail_q] <= 1'b1;
				end
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_q <= in_command;
			idx_q     <= in_buffer_index;
		end
		if (cmd.exec) begin
			out_status          <= st_d;
			out_granted_index   <= granted_d;
			out_available_count <= free_d;
			out_used_count      <= used_d;
		end
	end

	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q + used_q == pool_count_q)
		else $error("free plus used differs from pool count");

	a_used_marks: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(in_use_q) == int'(used_q))
		else $error("used count disagrees with in-use marks");

	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && command_q == CMD_ACQUIRE && free_count_q != '0 |-> mark_set)
		else $error("granted buffer was already in use");
endmodule

`default_nettype wire

/* sv/fifo_free_list_buffer_manager.sv */
// Free-list buffer manager. Items on cmd_in: command acquire, release or clear
// with a buffer index; one result per item on rsp_out with status, the
// granted index and the free and used counts after the item.
// cfg carries pool_count (saturated to the capacity of 64); a write refills
// the free list with 0 to pool_count-1 and frees every buffer, as clear does.
// Writes are taken in the idle state and win over an item offered together.
// An item is accepted in the idle state, where its list head is read (the
// free-list RAM has registered read), and applied in the fetch state, which
// also loads its result; no new item is taken before it is applied. The
// result waits in an output register; while it is not taken the next item
// is still accepted and its list head read, then held before its update
// until the register is free; items after it stall until then.
// Reset: the pool holds 64 buffers, all free and listed in order, nothing in
// use; no item is pending and rsp_out.valid is low.
// Depends on fflbm_pkg, the channel interfaces, fflbm_ctrl and fflbm_dp.
`default_nettype none

module fifo_free_list_buffer_manager (
	input wire logic  clk,
	input wire logic  arst_n,
	fflbm_cmd_if.sink cmd_in,
	fflbm_rsp_if.source rsp_out,
	fflbm_cfg_if.sink cfg
);
	import fflbm_pkg::*;

	ctl_cmd_t cmd;

	fflbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_in.valid),
		.in_ready  (cmd_in.ready),
		.out_valid (rsp_out.valid),
		.out_ready (rsp_out.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cmd       (cmd)
	);

	fflbm_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.in_command          (cmd_in.command),
		.in_buffer_index     (cmd_in.buffer_index),
		.cfg_data            (cfg.data),
		.out_status          (rsp_out.status),
		.out_granted_index   (rsp_out.granted_index),
		.out_available_count (rsp_out.available_count),
		.out_used_count      (rsp_out.used_count)
	);
endmodule

`default_nettype wire
